### hdl/gmvn_pkg.sv
package gmvn_pkg;

  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;

  localparam int PT_W   = 24;
  localparam int EDGE_W = PT_W + 1;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int CR_W   = PROD_W + 1;
  localparam int MAG_W  = CR_W - 1;
  localparam int NRM_W  = 16;
  localparam int ACC_W  = 18;
  localparam int CFG_W  = 9;
  localparam int DIM_W  = 14;
  localparam int ROOT_W = 25;
  localparam int REM_W  = ROOT_W + 2;
  localparam int QUO_W  = 15;
  localparam int DV_W   = 41;
  localparam int SQRT_STEPS = MAG_W / 2;
  localparam int TRI_N  = 6;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SEL   = 12'b000000000010,
    S_FETCH = 12'b000000000100,
    S_CROSS = 12'b000000001000,
    S_MAG   = 12'b000000010000,
    S_SHIFT = 12'b000000100000,
    S_SQ    = 12'b000001000000,
    S_SQRT  = 12'b000010000000,
    S_DLOAD = 12'b000100000000,
    S_DIV   = 12'b001000000000,
    S_ACC   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  typedef struct packed {
    logic down;
    logic up;
    logic right;
    logic left;
  } nbr_t;

  // {dr, dc}, each a 2-bit signed offset
  function automatic logic [3:0] tri_offset(input logic [2:0] t, input logic [1:0] v);
    logic [3:0] o;
    o = 4'b0000;
    case ({t, v})
      5'b000_00: o = 4'b00_00;
      5'b000_01: o = 4'b00_01;
      5'b000_10: o = 4'b01_00;
      5'b001_00: o = 4'b00_11;
      5'b001_01: o = 4'b00_00;
      5'b001_10: o = 4'b01_11;
      5'b010_00: o = 4'b11_00;
      5'b010_01: o = 4'b11_01;
      5'b010_10: o = 4'b00_00;
      5'b011_00: o = 4'b00_00;
      5'b011_01: o = 4'b01_00;
      5'b011_10: o = 4'b01_11;
      5'b100_00: o = 4'b11_00;
      5'b100_01: o = 4'b00_00;
      5'b100_10: o = 4'b00_11;
      5'b101_00: o = 4'b11_01;
      5'b101_01: o = 4'b00_01;
      5'b101_10: o = 4'b00_00;
      default:   o = 4'b0000;
    endcase
    return o;
  endfunction

  function automatic logic tri_enabled(input logic [2:0] t, input nbr_t nb);
    logic e;
    e = 1'b0;
    case (t)
      3'd0:    e = nb.down & nb.right;
      3'd1:    e = nb.down & nb.left;
      3'd2:    e = nb.up & nb.right;
      3'd3:    e = nb.down & nb.left;
      3'd4:    e = nb.up & nb.left;
      3'd5:    e = nb.up & nb.right;
      default: e = 1'b0;
    endcase
    return e;
  endfunction

endpackage

### hdl/grid_mesh_vertex_normal.sv
// Grid mesh vertex normal unit. A write item (func 0) stores one Q3.20 point at
// (row, col); writes outside the configured grid are dropped.
// A read item (func 1) returns one result: the Q1.14 unit normal of the vertex,
// the normalized sum of the unit normals of the up to six triangles around it,
// or outside_grid with zero normals when (row, col) is off the grid. A read
// keeps the unit busy: each triangle takes three point fetches from the store,
// six products on the one shared 25x25 multiplier, a one-bit-per-cycle square
// root of 25 steps and a one-bit-per-cycle divide of 15 steps for each of the
// three components, followed by a final normalization of the sum. Reading a
// point that was never written gives an undefined normal. The store needs no
// clearing pass after reset. The user must write configuration only while
// idle; the unit itself does not enforce this.
module grid_mesh_vertex_normal
  import gmvn_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    func,
  input  logic [7:0]              row,
  input  logic [7:0]              col,
  input  logic signed [PT_W-1:0]  point_x,
  input  logic signed [PT_W-1:0]  point_y,
  input  logic signed [PT_W-1:0]  point_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z,
  output logic                    outside_grid
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  state_t state;
  logic [4:0] cnt;
  logic [2:0] tri_idx;
  logic [1:0] kc;
  logic final_pass;
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;

  logic [7:0] row_q;
  logic [7:0] col_q;
  nbr_t nb;
  logic oflag;

  logic [3*PT_W-1:0] mem [DEPTH];
  logic [3*PT_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic wr_en;

  logic signed [PT_W-1:0] p0 [3];
  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  logic signed [EDGE_W-1:0] mul_a;
  logic signed [EDGE_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [CR_W-1:0] vec [3];
  logic [MAG_W-1:0] magv [3];
  logic neg [3];
  logic [MAG_W-1:0] s2;
  logic [MAG_W-1:0] sq_src;
  logic [REM_W-1:0] sq_rem;
  logic [ROOT_W-1:0] root;
  logic [DV_W-1:0] num;
  logic [DV_W-1:0] den_sh;
  logic [QUO_W-1:0] quo;
  logic signed [NRM_W-1:0] nres [3];
  logic signed [ACC_W-1:0] acc [3];

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] row_d;
  logic [DIM_W-1:0] col_d;
  logic in_acc;
  logic outside;
  logic load_out;
  logic big8;
  logic big1;
  logic [3:0] off;
  logic [DIM_W-1:0] rr;
  logic [DIM_W-1:0] cc;
  logic [REM_W+1:0] rem_t;
  logic [REM_W+1:0] trial;
  logic div_ge;
  logic [QUO_W-1:0] q_next;
  logic signed [NRM_W-1:0] div_res;

  always_comb begin
    if (grid_width < CFG_W'(2)) begin
      w_eff = DIM_W'(2);
    end else if (DIM_W'(grid_width) > DIM_W'(MAX_COLS)) begin
      w_eff = DIM_W'(MAX_COLS);
    end else begin
      w_eff = DIM_W'(grid_width);
    end
    if (grid_height < CFG_W'(2)) begin
      h_eff = DIM_W'(2);
    end else if (DIM_W'(grid_height) > DIM_W'(MAX_ROWS)) begin
      h_eff = DIM_W'(MAX_ROWS);
    end else begin
      h_eff = DIM_W'(grid_height);
    end
  end

  assign row_d    = DIM_W'(row);
  assign col_d    = DIM_W'(col);
  assign outside  = (row_d >= h_eff) || (col_d >= w_eff);
  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  assign wr_en   = in_acc && (func == FUNC_WRITE) && !outside;
  assign wr_addr = ADDR_W'(ADDR_W'(row_d) * ADDR_W'(MAX_COLS) + ADDR_W'(col_d));

  assign off     = tri_offset(tri_idx, cnt[1:0]);
  assign rr      = DIM_W'(row_q) + {{(DIM_W-2){off[3]}}, off[3:2]};
  assign cc      = DIM_W'(col_q) + {{(DIM_W-2){off[1]}}, off[1:0]};
  assign rd_addr = ADDR_W'(ADDR_W'(rr) * ADDR_W'(MAX_COLS) + ADDR_W'(cc));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {point_x, point_y, point_z};
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    big8 = 1'b0;
    big1 = 1'b0;
    for (int k = 0; k < 3; k++) begin
      big8 = big8 | (|magv[k][MAG_W-1:31]);
      big1 = big1 | (|magv[k][MAG_W-1:PT_W]);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_CROSS) begin
      case (cnt)
        5'd0:    begin mul_a = e2[1]; mul_b = e1[2]; end
        5'd1:    begin mul_a = e2[2]; mul_b = e1[1]; end
        5'd2:    begin mul_a = e2[2]; mul_b = e1[0]; end
        5'd3:    begin mul_a = e2[0]; mul_b = e1[2]; end
        5'd4:    begin mul_a = e2[0]; mul_b = e1[1]; end
        5'd5:    begin mul_a = e2[1]; mul_b = e1[0]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == S_SQ && cnt < 5'd3) begin
      mul_a = {1'b0, magv[cnt[1:0]][PT_W-1:0]};
      mul_b = {1'b0, magv[cnt[1:0]][PT_W-1:0]};
    end
  end

  assign rem_t   = {sq_rem, sq_src[MAG_W-1:MAG_W-2]};
  assign trial   = (REM_W+2)'({root, 2'b01});
  assign div_ge  = num >= den_sh;
  assign q_next  = {quo[QUO_W-2:0], div_ge};
  assign div_res = (root == '0) ? '0 :
                   (neg[kc] ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      tri_idx     <= '0;
      kc          <= '0;
      final_pass  <= 1'b0;
      out_valid   <= 1'b0;
      grid_width  <= CFG_W'(256);
      grid_height <= CFG_W'(256);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  grid_width <= cfg_data;
          CFG_GRID_HEIGHT: grid_height <= cfg_data;
          default:         grid_width <= grid_width;
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && func == FUNC_READ) begin
            tri_idx    <= '0;
            final_pass <= 1'b0;
            cnt        <= '0;
            state      <= outside ? S_DONE : S_SEL;
          end
        end
        S_SEL: begin
          if (tri_idx == 3'(TRI_N)) begin
            final_pass <= 1'b1;
            state      <= S_MAG;
          end else if (tri_enabled(tri_idx, nb)) begin
            cnt   <= '0;
            state <= S_FETCH;
          end else begin
            tri_idx <= tri_idx + 3'd1;
          end
        end
        S_FETCH: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            cnt   <= '0;
            state <= S_CROSS;
          end
        end
        S_CROSS: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd6) begin
            cnt   <= '0;
            state <= S_MAG;
          end
        end
        S_MAG: state <= S_SHIFT;
        S_SHIFT: begin
          if (!big1) begin
            cnt   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            cnt   <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(SQRT_STEPS - 1)) begin
            cnt   <= '0;
            kc    <= '0;
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(QUO_W - 1)) begin
            cnt <= '0;
            if (kc == 2'd2) begin
              state <= S_ACC;
            end else begin
              kc    <= kc + 2'd1;
              state <= S_DLOAD;
            end
          end
        end
        S_ACC: begin
          if (final_pass) begin
            state <= S_DONE;
          end else begin
            tri_idx <= tri_idx + 3'd1;
            state   <= S_SEL;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        if (in_acc && func == FUNC_READ) begin
          row_q    <= row;
          col_q    <= col;
          oflag    <= outside;
          nb.down  <= (row_d + DIM_W'(1)) < h_eff;
          nb.up    <= row_d >= DIM_W'(1);
          nb.right <= (col_d + DIM_W'(1)) < w_eff;
          nb.left  <= col_d >= DIM_W'(1);
          for (int k = 0; k < 3; k++) begin
            acc[k]  <= '0;
            nres[k] <= '0;
          end
        end
      end
      S_SEL: begin
        if (tri_idx == 3'(TRI_N)) begin
          for (int k = 0; k < 3; k++) begin
            vec[k] <= CR_W'(acc[k]);
          end
        end
      end
      S_FETCH: begin
        case (cnt)
          5'd1: begin
            p0[0] <= rd_data[3*PT_W-1:2*PT_W];
            p0[1] <= rd_data[2*PT_W-1:PT_W];
            p0[2] <= rd_data[PT_W-1:0];
          end
          5'd2: begin
            e1[0] <= EDGE_W'($signed(rd_data[3*PT_W-1:2*PT_W])) - EDGE_W'(p0[0]);
            e1[1] <= EDGE_W'($signed(rd_data[2*PT_W-1:PT_W])) - EDGE_W'(p0[1]);
            e1[2] <= EDGE_W'($signed(rd_data[PT_W-1:0])) - EDGE_W'(p0[2]);
          end
          5'd3: begin
            e2[0] <= EDGE_W'($signed(rd_data[3*PT_W-1:2*PT_W])) - EDGE_W'(p0[0]);
            e2[1] <= EDGE_W'($signed(rd_data[2*PT_W-1:PT_W])) - EDGE_W'(p0[1]);
            e2[2] <= EDGE_W'($signed(rd_data[PT_W-1:0])) - EDGE_W'(p0[2]);
          end
          default: p0[0] <= p0[0];
        endcase
      end
      S_CROSS: begin
        case (cnt)
          5'd1:    vec[0] <= CR_W'(prod);
          5'd2:    vec[0] <= vec[0] - CR_W'(prod);
          5'd3:    vec[1] <= CR_W'(prod);
          5'd4:    vec[1] <= vec[1] - CR_W'(prod);
          5'd5:    vec[2] <= CR_W'(prod);
          5'd6:    vec[2] <= vec[2] - CR_W'(prod);
          default: vec[0] <= vec[0];
        endcase
      end
      S_MAG: begin
        s2 <= '0;
        for (int k = 0; k < 3; k++) begin
          neg[k]  <= vec[k][CR_W-1];
          magv[k] <= vec[k][CR_W-1] ? MAG_W'(-vec[k]) : MAG_W'(vec[k]);
        end
      end
      S_SHIFT: begin
        for (int k = 0; k < 3; k++) begin
          if (big8) begin
            magv[k] <= magv[k] >> 8;
          end else if (big1) begin
            magv[k] <= magv[k] >> 1;
          end
        end
      end
      S_SQ: begin
        if (cnt != 5'd0) begin
          s2 <= s2 + MAG_W'(prod);
        end
        if (cnt == 5'd3) begin
          sq_src <= s2 + MAG_W'(prod);
          sq_rem <= '0;
          root   <= '0;
        end
      end
      S_SQRT: begin
        sq_src <= sq_src << 2;
        if (rem_t >= trial) begin
          sq_rem <= REM_W'(rem_t - trial);
          root   <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem <= REM_W'(rem_t);
          root   <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      S_DLOAD: begin
        num    <= DV_W'({magv[kc][PT_W-1:0], {QUO_W{1'b0}}}) + DV_W'(root);
        den_sh <= DV_W'({root, {QUO_W{1'b0}}});
        quo    <= '0;
      end
      S_DIV: begin
        if (div_ge) begin
          num <= num - den_sh;
        end
        den_sh <= den_sh >> 1;
        quo    <= q_next;
        if (cnt == 5'(QUO_W - 1)) begin
          nres[kc] <= div_res;
        end
      end
      S_ACC: begin
        if (!final_pass) begin
          for (int k = 0; k < 3; k++) begin
            acc[k] <= acc[k] + ACC_W'(nres[k]);
          end
        end
      end
      S_DONE: begin
        if (load_out) begin
          normal_x     <= nres[0];
          normal_y     <= nres[1];
          normal_z     <= nres[2];
          outside_grid <= oflag;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/gmvn_checker.sv
module gmvn_assert
  import gmvn_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    func,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [NRM_W-1:0] normal_x,
  input logic signed [NRM_W-1:0] normal_y,
  input logic signed [NRM_W-1:0] normal_z,
  input logic                    outside_grid
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y)
      && $stable(normal_z) && $stable(outside_grid))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x >= -16'sd16384 && normal_x <= 16'sd16384
      && normal_y >= -16'sd16384 && normal_y <= 16'sd16384
      && normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
    else $error("normal component out of range");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outside_grid |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("off-grid result with nonzero normal");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_READ |=> !in_ready)
    else $error("read item did not hold off input");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_WRITE && !out_valid |=> !out_valid)
    else $error("write item produced a result");

endmodule

bind grid_mesh_vertex_normal gmvn_assert u_gmvn_assert (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .func         (func),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .normal_x     (normal_x),
  .normal_y     (normal_y),
  .normal_z     (normal_z),
  .outside_grid (outside_grid)
);

### verif/gmvn_checker.sv
module gmvn_checker
  import gmvn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    func,
  input  logic [7:0]              row,
  input  logic [7:0]              col,
  input  logic signed [PT_W-1:0]  point_x,
  input  logic signed [PT_W-1:0]  point_y,
  input  logic signed [PT_W-1:0]  point_z,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [NRM_W-1:0] normal_x,
  input  logic signed [NRM_W-1:0] normal_y,
  input  logic signed [NRM_W-1:0] normal_z,
  input  logic                    outside_grid,
  output int                      fail_count,
  output int                      normals_pending
);

  typedef struct {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    off;
  } vnormal_t;

  localparam int COLS = MAX_COLS_DEF;
  localparam int ROWS = MAX_ROWS_DEF;

  logic signed [PT_W-1:0] pt_x [COLS*ROWS];
  logic signed [PT_W-1:0] pt_y [COLS*ROWS];
  logic signed [PT_W-1:0] pt_z [COLS*ROWS];
  logic [CFG_W-1:0] width_reg, height_reg;
  vnormal_t normal_q[$];

  assign normals_pending = normal_q.size();

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned root64(input longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void unit_vec(input longint vx, vy, vz, output longint ox, oy, oz);
    longint unsigned ax, ay, az, m, s2, n;
    int sh;
    ax = (vx < 0) ? -vx : vx;
    ay = (vy < 0) ? -vy : vy;
    az = (vz < 0) ? -vz : vz;
    m = ax;
    if (ay > m) m = ay;
    if (az > m) m = az;
    sh = 0;
    while ((m >> sh) >= (64'd1 << 24)) sh++;
    ax = ax >> sh;
    ay = ay >> sh;
    az = az >> sh;
    s2 = ax * ax + ay * ay + az * az;
    n = root64(s2);
    if (n == 0) begin
      ox = 0;
      oy = 0;
      oz = 0;
    end else begin
      ox = (ax * 32768 + n) / (2 * n);
      oy = (ay * 32768 + n) / (2 * n);
      oz = (az * 32768 + n) / (2 * n);
      if (vx < 0) ox = -ox;
      if (vy < 0) oy = -oy;
      if (vz < 0) oz = -oz;
    end
  endfunction

  function automatic void add_face(input int r0, c0, r1, c1, r2, c2,
                                   inout longint sx, sy, sz);
    longint p0x, p0y, p0z, e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz, ux, uy, uz;
    p0x = pt_x[r0*COLS+c0];
    p0y = pt_y[r0*COLS+c0];
    p0z = pt_z[r0*COLS+c0];
    e1x = longint'(pt_x[r1*COLS+c1]) - p0x;
    e1y = longint'(pt_y[r1*COLS+c1]) - p0y;
    e1z = longint'(pt_z[r1*COLS+c1]) - p0z;
    e2x = longint'(pt_x[r2*COLS+c2]) - p0x;
    e2y = longint'(pt_y[r2*COLS+c2]) - p0y;
    e2z = longint'(pt_z[r2*COLS+c2]) - p0z;
    cx = e2y * e1z - e2z * e1y;
    cy = e2z * e1x - e2x * e1z;
    cz = e2x * e1y - e2y * e1x;
    unit_vec(cx, cy, cz, ux, uy, uz);
    sx += ux;
    sy += uy;
    sz += uz;
  endfunction

  function automatic vnormal_t vertex_normal(input int r, c);
    vnormal_t e;
    longint sx, sy, sz, ox, oy, oz;
    int w, h;
    bit dn, up, rt, lf;
    w = clamp_dim(width_reg, COLS);
    h = clamp_dim(height_reg, ROWS);
    e.nx = 0;
    e.ny = 0;
    e.nz = 0;
    e.off = (r >= h) || (c >= w);
    if (!e.off) begin
      sx = 0;
      sy = 0;
      sz = 0;
      dn = r + 1 < h;
      up = r >= 1;
      rt = c + 1 < w;
      lf = c >= 1;
      if (dn && rt) add_face(r, c, r, c+1, r+1, c, sx, sy, sz);
      if (dn && lf) add_face(r, c-1, r, c, r+1, c-1, sx, sy, sz);
      if (up && rt) add_face(r-1, c, r-1, c+1, r, c, sx, sy, sz);
      if (dn && lf) add_face(r, c, r+1, c, r+1, c-1, sx, sy, sz);
      if (up && lf) add_face(r-1, c, r, c, r, c-1, sx, sy, sz);
      if (up && rt) add_face(r-1, c+1, r, c+1, r, c, sx, sy, sz);
      unit_vec(sx, sy, sz, ox, oy, oz);
      e.nx = NRM_W'(ox);
      e.ny = NRM_W'(oy);
      e.nz = NRM_W'(oz);
    end
    return e;
  endfunction

  always @(posedge clk) begin
    vnormal_t e;
    int idx;
    if (rst) begin
      width_reg <= 9'd256;
      height_reg <= 9'd256;
      fail_count <= 0;
      normal_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_WIDTH) width_reg <= cfg_data;
        else height_reg <= cfg_data;
      end
      if (in_valid && in_ready) begin
        if (func == FUNC_WRITE) begin
          if (row < clamp_dim(height_reg, ROWS) && col < clamp_dim(width_reg, COLS)) begin
            idx = row * COLS + col;
            pt_x[idx] = point_x;
            pt_y[idx] = point_y;
            pt_z[idx] = point_z;
          end
        end else begin
          normal_q.push_back(vertex_normal(row, col));
        end
      end
      if (out_valid && out_ready) begin
        if (normal_q.size() == 0) begin
          $display("%0t: unexpected item: normal %0d %0d %0d outside %0b", $time,
                   normal_x, normal_y, normal_z, outside_grid);
          fail_count <= fail_count + 1;
        end else begin
          e = normal_q.pop_front();
          if (e.nx !== normal_x || e.ny !== normal_y || e.nz !== normal_z ||
              e.off !== outside_grid) begin
            $display("%0t: mismatch: expected %0d %0d %0d outside %0b, %s",
                     $time, e.nx, e.ny, e.nz, e.off,
                     $sformatf("got %0d %0d %0d outside %0b",
                               normal_x, normal_y, normal_z, outside_grid));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### verif/tb_top.sv
module tb_top
  import gmvn_pkg::*;
();

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we, cfg_index, in_valid, in_ready, func, out_valid, out_ready, outside_grid;
  logic [CFG_W-1:0] cfg_data;
  logic [7:0] row, col;
  logic signed [PT_W-1:0] point_x, point_y, point_z;
  logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
  int fail_count, normals_pending, idle_cycles, stall_hold;
  int eff_w, eff_h;
  bit written [MAX_COLS_DEF*MAX_ROWS_DEF];

  grid_mesh_vertex_normal i_dut (.*);

  gmvn_checker i_chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_ready <= ($urandom_range(0, 2) != 0);
      stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 3);
    end
  end

  function automatic logic signed [PT_W-1:0] coord();
    case ($urandom_range(0, 7))
      0: return 24'sh800000;
      1: return 24'sh7fffff;
      2: return '0;
      3: return PT_W'($urandom_range(0, 4096) - 2048);
      default: return PT_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic f, input int r, c,
                           input logic signed [PT_W-1:0] x, y, z);
    int gap;
    func <= f;
    row <= 8'(r);
    col <= 8'(c);
    point_x <= x;
    point_y <= y;
    point_z <= z;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    gap = $urandom_range(0, 9);
    gap = (gap < 5) ? 0 : (gap < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_point(input int r, c, input logic signed [PT_W-1:0] x, y, z);
    send_item(FUNC_WRITE, r, c, x, y, z);
    if (r < eff_h && c < eff_w) written[r*MAX_COLS_DEF+c] = 1'b1;
  endtask

  function automatic bit can_read(input int r, c);
    if (r >= eff_h || c >= eff_w) return 1'b1;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (r+dr >= 0 && r+dr < eff_h && c+dc >= 0 && c+dc < eff_w)
          if (!written[(r+dr)*MAX_COLS_DEF+c+dc]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic pick_pos(output int r, c);
    int m;
    m = $urandom_range(0, 9);
    if (m < 5) begin
      r = $urandom_range(0, (eff_h < 6 ? eff_h : 6) - 1);
      c = $urandom_range(0, (eff_w < 6 ? eff_w : 6) - 1);
    end else if (m < 8) begin
      r = $urandom_range(eff_h >= 3 ? eff_h - 3 : 0, eff_h - 1);
      c = $urandom_range(eff_w >= 3 ? eff_w - 3 : 0, eff_w - 1);
    end else begin
      r = $urandom_range(0, 255);
      c = $urandom_range(0, 255);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (normals_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic int clamp_dim(input int v);
    return v < 2 ? 2 : v > 256 ? 256 : v;
  endfunction

  task automatic set_grid(input int w, h);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_data <= CFG_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_w = clamp_dim(w & 9'h1ff);
    eff_h = clamp_dim(h & 9'h1ff);
  endtask

  task automatic run_phase(input int n);
    int r, c, m;
    for (r = 0; r < (eff_h < 6 ? eff_h : 6); r++)
      for (c = 0; c < (eff_w < 6 ? eff_w : 6); c++)
        put_point(r, c, coord(), coord(), coord());
    for (r = (eff_h >= 3 ? eff_h - 3 : 0); r < eff_h; r++)
      for (c = (eff_w >= 3 ? eff_w - 3 : 0); c < eff_w; c++)
        put_point(r, c, coord(), coord(), coord());
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(0, 19);
      pick_pos(r, c);
      if (m < 2) begin
        put_point($urandom_range(0, 255), $urandom_range(0, 255), coord(), coord(), coord());
      end else if (m < 12 && can_read(r, c)) begin
        send_item(FUNC_READ, r, c, PT_W'($urandom), PT_W'($urandom), PT_W'($urandom));
      end else if (r < eff_h && c < eff_w) begin
        put_point(r, c, coord(), coord(), coord());
      end else begin
        send_item(FUNC_READ, r, c, PT_W'($urandom), PT_W'($urandom), PT_W'($urandom));
      end
    end
  endtask

  initial begin
    cfg_we <= 1'b0;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    func <= FUNC_WRITE;
    row <= '0;
    col <= '0;
    point_x <= '0;
    point_y <= '0;
    point_z <= '0;
    out_ready <= 1'b0;
    stall_hold <= 0;
    eff_w = 256;
    eff_h = 256;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // degenerate patch reads as zero
    put_point(0, 0, 0, 0, 0);
    put_point(0, 1, 0, 0, 0);
    put_point(1, 0, 0, 0, 0);
    put_point(1, 1, 0, 0, 0);
    send_item(FUNC_READ, 0, 0, 0, 0, 0);
    put_point(0, 0, 24'sh800000, 24'sh800000, 24'sh800000);
    put_point(0, 1, 24'sh7fffff, 24'sh800000, 24'sh7fffff);
    put_point(1, 0, 24'sh800000, 24'sh7fffff, 24'sh7fffff);
    put_point(1, 1, 24'sh7fffff, 24'sh7fffff, 24'sh800000);
    put_point(0, 2, coord(), coord(), coord());
    put_point(1, 2, coord(), coord(), coord());
    put_point(2, 0, coord(), coord(), coord());
    put_point(2, 1, coord(), coord(), coord());
    put_point(2, 2, coord(), coord(), coord());
    send_item(FUNC_READ, 0, 0, 0, 0, 0);
    send_item(FUNC_READ, 1, 1, 0, 0, 0);
    send_item(FUNC_READ, 0, 1, 0, 0, 0);
    put_point(255, 255, 24'sh7fffff, 0, 24'sh800000);
    put_point(255, 254, 0, 24'sh7fffff, 0);
    put_point(254, 255, 24'sh800000, 24'sh800000, 0);
    put_point(254, 254, 1, 1, 1);
    put_point(253, 253, coord(), coord(), coord());
    put_point(253, 254, coord(), coord(), coord());
    put_point(253, 255, coord(), coord(), coord());
    put_point(254, 253, coord(), coord(), coord());
    put_point(255, 253, coord(), coord(), coord());
    send_item(FUNC_READ, 255, 255, 0, 0, 0);
    send_item(FUNC_READ, 254, 254, 0, 0, 0);
    run_phase(60);

    set_grid(2, 2);
    send_item(FUNC_READ, 2, 0, 0, 0, 0);
    send_item(FUNC_READ, 0, 255, 0, 0, 0);
    put_point(3, 3, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    run_phase(55);
    set_grid(256, 2);
    run_phase(55);
    set_grid(2, 256);
    run_phase(55);
    set_grid(0, 1);
    run_phase(55);
    set_grid(511, 300);
    run_phase(55);
    set_grid(5, 3);
    run_phase(55);
    set_grid(9, 7);
    run_phase(55);
    set_grid(256, 256);
    run_phase(55);

    wait_idle();
    if (fail_count == 0 && normals_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
